// ===== sv/lkv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_pkg
// Types and constants shared by the LRU key/value cache modules.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int DATA_W  = 32;
    localparam int CFG_W   = 5;

    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef struct packed {
        logic                     req_type;
        logic signed [DATA_W-1:0] lookup_key;
        logic signed [DATA_W-1:0] store_value;
    } t_in_item;

    typedef struct packed {
        logic                     found;
        logic signed [DATA_W-1:0] read_value;
        logic                     evicted;
    } t_out_item;

    // Flags produced by the shared entry probe for one entry.
    typedef struct packed {
        logic hit;
        logic oldest;
        logic free;
    } t_probe;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

endpackage
`default_nettype wire

// ===== sv/lkv_probe.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_probe
// Shared compare unit: classifies one entry against the request key.
// ----------------------------------------------------------------------------
module lkv_probe (
    input  var logic [lkv_pkg::DATA_W-1:0] i_entry_key,
    input  var logic                       i_entry_valid,
    input  var logic [lkv_pkg::IDX_W-1:0]  i_entry_rank,
    input  var logic [lkv_pkg::DATA_W-1:0] i_req_key,
    input  var logic [lkv_pkg::IDX_W-1:0]  i_oldest_rank,
    output lkv_pkg::t_probe                o_probe
);

    always_comb begin
        o_probe.hit    = i_entry_valid && (i_entry_key == i_req_key);
        o_probe.oldest = i_entry_valid && (i_entry_rank == i_oldest_rank);
        o_probe.free   = !i_entry_valid;
    end

endmodule
`default_nettype wire

// ===== sv/lru_key_value_cache_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  -------   -------------------------  ---------------------------------
//  in        i_in_valid / o_in_stall    i_in_item  (req_type, key, value)
//  out       o_out_valid / i_out_stall  o_out_item (found, value, evicted)
//  config    i_cfg_we                   i_cfg_data (capacity_in_use)
//
// An item passes through accept, a probe walk over every entry in turn through
// the single compare unit, and commit; a new item is accepted only in idle.
// Reset clears all valid bits and the fill count, and sets capacity to 16.
// A result sits in the output register until taken; the commit step waits
// while an earlier result is still stalled there.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core (
    input  var logic                          i_clk,
    input  var logic                          i_rst_n,
    input  var logic                          i_in_valid,
    output var logic                          o_in_stall,
    input  var lkv_pkg::t_in_item             i_in_item,
    output var logic                          o_out_valid,
    input  var logic                          i_out_stall,
    output lkv_pkg::t_out_item                o_out_item,
    input  var logic                          i_cfg_we,
    input  var logic [lkv_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int N  = lkv_pkg::ENTRIES;
    localparam int IW = lkv_pkg::IDX_W;
    localparam int CW = lkv_pkg::CNT_W;
    localparam int DW = lkv_pkg::DATA_W;

    // Entry storage. Ranks and valid bits update in parallel at commit.
    logic [DW-1:0] r_keys   [N];
    logic [DW-1:0] r_values [N];
    logic [IW-1:0] r_ranks  [N];
    logic [N-1:0]  r_valid;
    logic [CW-1:0] r_fill;
    logic [lkv_pkg::CFG_W-1:0] r_cap;

    lkv_pkg::t_state r_state, n_state;

    // Captured request and scan results.
    lkv_pkg::t_in_item r_req;
    logic [IW-1:0] r_idx;
    logic          r_hit;
    logic [IW-1:0] r_hit_idx;
    logic          r_old_seen;
    logic [IW-1:0] r_old_idx;
    logic          r_free_seen;
    logic [IW-1:0] r_free_idx;

    logic               r_out_valid;
    lkv_pkg::t_out_item r_out;

    logic            accept;
    logic            commit;
    logic            scan_last;
    logic [CW-1:0]   eff_cap;
    logic            need_evict;
    logic [IW-1:0]   put_slot;
    lkv_pkg::t_probe probe;

    // Least recent valid entry carries rank fill-1.
    lkv_probe u_probe (
        .i_entry_key   (r_keys[r_idx]),
        .i_entry_valid (r_valid[r_idx]),
        .i_entry_rank  (r_ranks[r_idx]),
        .i_req_key     (r_req.lookup_key),
        .i_oldest_rank (IW'(r_fill - CW'(1))),
        .o_probe       (probe)
    );

    // Clamp capacity to 1..ENTRIES.
    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CW'(1);
        end else if (int'(r_cap) > N) begin
            eff_cap = CW'(N);
        end else begin
            eff_cap = CW'(r_cap);
        end
    end

    assign scan_last  = (r_idx == IW'(N - 1));
    assign need_evict = (r_fill >= eff_cap);
    assign put_slot   = need_evict ? r_old_idx : r_free_idx;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            lkv_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = lkv_pkg::ST_SCAN;
            end
            lkv_pkg::ST_SCAN: begin
                if (scan_last) n_state = lkv_pkg::ST_COMMIT;
            end
            lkv_pkg::ST_COMMIT: begin
                if (!r_out_valid || !i_out_stall) n_state = lkv_pkg::ST_IDLE;
            end
            default: n_state = lkv_pkg::ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        o_in_stall = 1'b1;
        commit     = 1'b0;
        case (r_state)
            lkv_pkg::ST_IDLE:   o_in_stall = 1'b0;
            lkv_pkg::ST_SCAN:   o_in_stall = 1'b1;
            lkv_pkg::ST_COMMIT: commit     = !r_out_valid || !i_out_stall;
            default:            o_in_stall = 1'b1;
        endcase
    end

    assign accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lkv_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lkv_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    // Capture the request and walk the entries through the probe.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req       <= i_in_item;
            r_idx       <= '0;
            r_hit       <= 1'b0;
            r_hit_idx   <= '0;
            r_old_seen  <= 1'b0;
            r_old_idx   <= '0;
            r_free_seen <= 1'b0;
            r_free_idx  <= '0;
        end else if (r_state == lkv_pkg::ST_SCAN) begin
            if (!scan_last) r_idx <= r_idx + IW'(1);
            if (probe.hit && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_idx;
            end
            if (probe.oldest && !r_old_seen) begin
                r_old_seen <= 1'b1;
                r_old_idx  <= r_idx;
            end
            // Keep the lowest free index.
            if (probe.free && !r_free_seen) begin
                r_free_seen <= 1'b1;
                r_free_idx  <= r_idx;
            end
        end
    end

    // Commit: update entries and ranks, fill count and valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_fill  <= '0;
        end else if (commit) begin
            if (r_hit) begin
                // Age entries younger than the hit one; hit becomes most recent.
                for (int i = 0; i < N; i++) begin
                    if (r_valid[i] && (r_ranks[i] < r_ranks[r_hit_idx])) begin
                        r_ranks[i] <= r_ranks[i] + IW'(1);
                    end
                end
                r_ranks[r_hit_idx] <= '0;
                if (r_req.req_type == lkv_pkg::REQ_PUT) begin
                    r_values[r_hit_idx] <= r_req.store_value;
                end
            end else if (r_req.req_type == lkv_pkg::REQ_PUT) begin
                // Miss: age every other valid entry, reuse the oldest if full, insert.
                for (int i = 0; i < N; i++) begin
                    if (r_valid[i] && (IW'(i) != put_slot)) begin
                        r_ranks[i] <= r_ranks[i] + IW'(1);
                    end
                end
                r_ranks[put_slot]  <= '0;
                r_keys[put_slot]   <= r_req.lookup_key;
                r_values[put_slot] <= r_req.store_value;
                r_valid[put_slot]  <= 1'b1;
                if (!need_evict) r_fill <= r_fill + CW'(1);
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out.found <= r_hit;
            if (r_req.req_type == lkv_pkg::REQ_GET) begin
                r_out.read_value <= r_hit ? r_values[r_hit_idx] : '1;
                r_out.evicted    <= 1'b0;
            end else begin
                r_out.read_value <= '0;
                r_out.evicted    <= !r_hit && need_evict;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire
